### hdl/ccs_pkg.sv
package ccs_pkg;

    localparam int DoubleRounds = 10;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_block;

    localparam t_word Sigma0 = 32'h6170_7865;
    localparam t_word Sigma1 = 32'h3320_646e;
    localparam t_word Sigma2 = 32'h7962_2d32;
    localparam t_word Sigma3 = 32'h6b20_6574;

    typedef enum logic [2:0] {
        CFG_KEY_01    = 3'd0,
        CFG_KEY_23    = 3'd1,
        CFG_KEY_45    = 3'd2,
        CFG_KEY_67    = 3'd3,
        CFG_NONCE_LO  = 3'd4,
        CFG_NONCE_HI  = 3'd5,
        CFG_INIT_CTR  = 3'd6
    } t_cfg_idx;

    // request from the byte path to the block generator
    typedef struct packed {
        logic  start;
        t_word counter;
    } t_gen_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_gen_stat;

    // initial state: constants, key, counter, nonce
    function automatic t_block init_block(input logic [255:0] key, input logic [95:0] nonce,
                                          input t_word ctr);
        t_block b;
        b[0] = Sigma0;
        b[1] = Sigma1;
        b[2] = Sigma2;
        b[3] = Sigma3;
        for (int i = 0; i < 8; i++) begin
            b[4 + i] = key[32 * i +: 32];
        end
        b[12] = ctr;
        for (int i = 0; i < 3; i++) begin
            b[13 + i] = nonce[32 * i +: 32];
        end
        return b;
    endfunction

endpackage

### hdl/ccs_if.sv
interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_in, output first_byte, output last_byte,
                    input ready);
    modport sink (input valid, input data_in, input first_byte, input last_byte,
                  output ready);
endinterface

interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_out;

    modport source (output valid, output data_out, output last_out, input ready);
    modport sink (input valid, input data_out, input last_out, output ready);
endinterface

interface ccs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/ccs_qr_half.sv
// Half of a quarter-round: two add/xor/rotate pairs.
module ccs_qr_half (
    input  ccs_pkg::t_word i_a,
    input  ccs_pkg::t_word i_b,
    input  ccs_pkg::t_word i_c,
    input  ccs_pkg::t_word i_d,
    input  logic           i_second,
    output ccs_pkg::t_word o_a,
    output ccs_pkg::t_word o_b,
    output ccs_pkg::t_word o_c,
    output ccs_pkg::t_word o_d
);

    ccs_pkg::t_word dx;
    ccs_pkg::t_word bx;

    assign o_a = i_a + i_b;
    assign dx  = i_d ^ o_a;
    // rotate by 16 then 12 in the first half, by 8 then 7 in the second
    assign o_d = i_second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    assign o_c = i_c + o_d;
    assign bx  = i_b ^ o_c;
    assign o_b = i_second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};

endmodule

### hdl/ccs_block_gen.sv
// Block generator: the state sits as four rows of four words; the shared unit always
// works on column 0 and the rows rotate after each quarter-round, so diagonals line up
// as columns by an extra rotation at the end of the column round.
module ccs_block_gen #(
    parameter int DOUBLE_ROUNDS = ccs_pkg::DoubleRounds
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccs_pkg::t_gen_req  i_req,
    input  logic [255:0]       i_key,
    input  logic [95:0]        i_nonce,
    output ccs_pkg::t_gen_stat o_stat,
    output ccs_pkg::t_block    o_words
);

    localparam int DrW = $clog2(DOUBLE_ROUNDS);
    localparam logic [DrW-1:0] LastDr = DrW'(DOUBLE_ROUNDS - 1);
    localparam logic [2:0] LastColStep  = 3'd3;
    localparam logic [2:0] LastDiagStep = 3'd7;

    typedef enum logic [2:0] {
        G_IDLE = 3'b001,
        G_RUN  = 3'b010,
        G_FEED = 3'b100
    } t_gstate;

    t_gstate          r_state, n_state;
    logic             r_half, n_half;
    logic [2:0]       r_step, n_step;
    logic [DrW-1:0]   r_dr, n_dr;
    ccs_pkg::t_block  r_w, n_w;
    ccs_pkg::t_word   r_ctr, n_ctr;

    ccs_pkg::t_block  init_w;
    ccs_pkg::t_block  upd_w;
    ccs_pkg::t_word   q_a, q_b, q_c, q_d;
    logic [1:0]       rot_amt [4];

    ccs_qr_half u_qr (
        .i_a      (r_w[0]),
        .i_b      (r_w[4]),
        .i_c      (r_w[8]),
        .i_d      (r_w[12]),
        .i_second (r_half),
        .o_a      (q_a),
        .o_b      (q_b),
        .o_c      (q_c),
        .o_d      (q_d)
    );

    assign init_w = ccs_pkg::init_block(i_key, i_nonce,
                                        (r_state == G_IDLE) ? i_req.counter : r_ctr);

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (r_step == LastColStep) begin
                rot_amt[r] = 2'(1 + r);
            end else if (r_step == LastDiagStep) begin
                rot_amt[r] = 2'(1 - r);
            end else begin
                rot_amt[r] = 2'd1;
            end
        end
    end

    always_comb begin
        upd_w     = r_w;
        upd_w[0]  = q_a;
        upd_w[4]  = q_b;
        upd_w[8]  = q_c;
        upd_w[12] = q_d;
    end

    always_comb begin
        logic [1:0] sel;
        n_state = r_state;
        n_half  = r_half;
        n_step  = r_step;
        n_dr    = r_dr;
        n_w     = r_w;
        n_ctr   = r_ctr;
        sel     = 2'd0;
        case (r_state)
            G_IDLE: begin
                if (i_req.start) begin
                    n_w     = init_w;
                    n_ctr   = i_req.counter;
                    n_half  = 1'b0;
                    n_step  = 3'd0;
                    n_dr    = '0;
                    n_state = G_RUN;
                end
            end
            G_RUN: begin
                if (!r_half) begin
                    n_w = upd_w;
                end else begin
                    for (int r = 0; r < 4; r++) begin
                        for (int j = 0; j < 4; j++) begin
                            sel = 2'(j) + rot_amt[r];
                            n_w[4 * r + j] = upd_w[{2'(r), sel}];
                        end
                    end
                    n_step = r_step + 3'd1;
                    if (r_step == LastDiagStep) begin
                        n_dr = r_dr + DrW'(1);
                        if (r_dr == LastDr) begin
                            n_state = G_FEED;
                        end
                    end
                end
                n_half = !r_half;
            end
            G_FEED: begin
                for (int i = 0; i < 16; i++) begin
                    n_w[i] = r_w[i] + init_w[i];
                end
                n_state = G_IDLE;
            end
            default: begin
                n_state = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_half  <= 1'b0;
            r_step  <= 3'd0;
            r_dr    <= '0;
        end else begin
            r_state <= n_state;
            r_half  <= n_half;
            r_step  <= n_step;
            r_dr    <= n_dr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_ctr <= n_ctr;
    end

    assign o_stat.busy = (r_state != G_IDLE);
    assign o_stat.done = (r_state == G_FEED);
    assign o_words     = r_w;

endmodule

### hdl/chacha20_stream_cipher.sv
// ChaCha20 byte stream cipher (96-bit nonce, 32-bit block counter). Write key, nonce and
// initial counter through the configuration channel while no request is in flight; they
// apply from the next keystream block. Each input request yields one output byte, the
// input XOR the next keystream byte, with last_out copied from last_byte. A request with
// first_byte set reloads the counter and starts a fresh block; otherwise a new block is
// made once all 64 bytes are used, the counter wrapping at 2^32. Within a block a byte's
// result is registered and the next byte can be taken while the output is taken. A new
// block is made by loading the initial state, running the rounds one half quarter-round
// per cycle on a single shared adder/rotate unit and adding the initial state back; the
// byte then waits for a free output. The input is not ready while a block is being made.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = ccs_pkg::DoubleRounds
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccs_in_if.sink    i_in,
    ccs_out_if.source o_out,
    ccs_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_GEN  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [6:0]          r_pos, n_pos;
    ccs_pkg::t_word      r_ctr, n_ctr;
    logic [255:0]        r_key;
    logic [95:0]         r_nonce;
    ccs_pkg::t_word      r_init_ctr;
    logic                r_ovalid, n_ovalid;
    logic [7:0]          r_odata, n_odata;
    logic                r_olast, n_olast;
    logic [7:0]          r_sdata;
    logic                r_slast;

    ccs_pkg::t_gen_req   s_req;
    ccs_pkg::t_gen_stat  s_stat;
    ccs_pkg::t_block     s_words;

    logic                in_acc;
    logic                out_free;
    logic                need_blk;
    ccs_pkg::t_word      ctr_use;
    ccs_pkg::t_word      ks_word;
    logic [7:0]          ks_byte;

    ccs_block_gen #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .i_key   (r_key),
        .i_nonce (r_nonce),
        .o_stat  (s_stat),
        .o_words (s_words)
    );

    assign out_free    = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign need_blk    = i_in.first_byte || r_pos[6];
    assign ctr_use     = i_in.first_byte ? r_init_ctr : r_ctr;

    assign ks_word = s_words[r_pos[5:2]];
    assign ks_byte = 8'(ks_word >> {r_pos[1:0], 3'b000});

    assign s_req.start   = in_acc && need_blk;
    assign s_req.counter = ctr_use;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_ctr    = r_ctr;
        n_ovalid = r_ovalid && !o_out.ready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (need_blk) begin
                        n_ctr   = ctr_use + 32'd1;
                        n_pos   = 7'd0;
                        n_state = S_GEN;
                    end else begin
                        n_odata  = i_in.data_in ^ ks_byte;
                        n_olast  = i_in.last_byte;
                        n_ovalid = 1'b1;
                        n_pos    = r_pos + 7'd1;
                    end
                end
            end
            S_GEN: begin
                if (s_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_odata  = r_sdata ^ ks_byte;
                    n_olast  = r_slast;
                    n_ovalid = 1'b1;
                    n_pos    = r_pos + 7'd1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= 7'd64;
            r_ctr      <= '0;
            r_ovalid   <= 1'b0;
            r_key      <= '0;
            r_nonce    <= '0;
            r_init_ctr <= '0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_ctr    <= n_ctr;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    ccs_pkg::CFG_KEY_01:   r_key[63:0]    <= i_cfg.data;
                    ccs_pkg::CFG_KEY_23:   r_key[127:64]  <= i_cfg.data;
                    ccs_pkg::CFG_KEY_45:   r_key[191:128] <= i_cfg.data;
                    ccs_pkg::CFG_KEY_67:   r_key[255:192] <= i_cfg.data;
                    ccs_pkg::CFG_NONCE_LO: r_nonce[63:0]  <= i_cfg.data;
                    ccs_pkg::CFG_NONCE_HI: r_nonce[95:64] <= i_cfg.data[31:0];
                    ccs_pkg::CFG_INIT_CTR: r_init_ctr     <= i_cfg.data[31:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // register the output byte and hold the request that waits for its block
    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_olast <= n_olast;
        if (in_acc) begin
            r_sdata <= i_in.data_in;
            r_slast <= i_in.last_byte;
        end
    end

    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_ovalid;
    assign o_out.data_out = r_odata;
    assign o_out.last_out = r_olast;

    a_first_starts_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.first_byte) |=> (r_state == S_GEN) && s_stat.busy)
        else $error("first byte did not start a new block");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 7'd64)
        else $error("byte position beyond block end");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.busy |-> !i_in.ready)
        else $error("input ready while block generator busy");

    a_done_only_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.done |-> (r_state == S_GEN))
        else $error("block finished with no request waiting");

    a_accept_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !need_blk) |=> o_out.valid && (r_state == S_IDLE))
        else $error("request within block gave no result");

endmodule
